>>> design/bxtp_pkg.sv
package bxtp_pkg;

  localparam int MAX_DEPTH_DEF = 255;
  localparam int DEPTH_CAP     = 255;
  localparam logic [7:0] SIZE_ESC = 8'd255;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_TABSIZE  = 4'd1,
    PH_NAMES    = 4'd2,
    PH_NODETYPE = 4'd3,
    PH_TAGIDX   = 4'd4,
    PH_ATTRIDX  = 4'd5,
    PH_ATTRVAL  = 4'd6,
    PH_TEXT     = 4'd7,
    PH_DONE     = 4'd8,
    PH_ERROR    = 4'd9
  } phase_t;

  typedef enum logic [3:0] {
    TK_NAME_BYTE = 4'd0,
    TK_NAME_END  = 4'd1,
    TK_OPEN      = 4'd2,
    TK_SELF      = 4'd3,
    TK_ATTR_NAME = 4'd4,
    TK_ATTR_BYTE = 4'd5,
    TK_ATTR_END  = 4'd6,
    TK_TEXT_BYTE = 4'd7,
    TK_TEXT_END  = 4'd8,
    TK_CLOSE     = 4'd9,
    TK_ERROR     = 4'd10
  } token_kind_t;

  localparam logic [7:0] NT_OPEN  = 8'd1;
  localparam logic [7:0] NT_TEXT  = 8'd3;
  localparam logic [7:0] NT_CLOSE = 8'd0;

endpackage

>>> design/binary_xml_token_parser_unit.sv
// Binary XML token parser.
// Input stream: one document byte per word on in_tdata; in_tuser high marks
// the first byte of a file and restarts the parser at its 4-byte header.
// Result stream: at most one token per input byte. out_tuser carries the
// token kind, out_tdata the token value and the nesting depth after the
// token, out_tlast flags the token that completes the root node.
// Bytes that give no token (header, size codes, node types, end of
// attributes) are consumed silently.
// An accepted byte is held in the input register, then its token goes to the
// result register.
// Throughput: one byte per cycle while the receiver takes tokens; the per-byte
// state update is a small phase machine with one 16-bit size decode and compare.
// If the receiver stalls, the pending token holds in the result register,
// the next byte waits in the input register, and in_tready drops once both
// are full.
// Reset puts the parser at the header with empty result register.
// After an error token the parser stays silent until the next file start.
module binary_xml_token_parser_unit #(
  parameter int MAX_DEPTH = bxtp_pkg::MAX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] start_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] token_value, [23:16] nesting_level
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic        out_tlast   // document_done
);

  localparam int DEPTH_LIM_I = (MAX_DEPTH < bxtp_pkg::DEPTH_CAP) ? MAX_DEPTH
                                                                 : bxtp_pkg::DEPTH_CAP;
  localparam logic [7:0] DepthLimit = DEPTH_LIM_I[7:0];

  logic                  in_valid_r;
  logic [7:0]            in_byte_r;
  logic                  in_sof_r;

  bxtp_pkg::phase_t      phase_r, phase_nxt, ph_c;
  logic [1:0]            hdr_cnt_r, hdr_cnt_nxt, hdr_c;
  logic [1:0]            sz_step_r, sz_step_nxt, szs_c;
  logic [7:0]            sz_high_r, sz_high_nxt, szh_c;
  logic [15:0]           name_total_r, name_total_nxt, ntot_c;
  logic [15:0]           names_left_r, names_left_nxt, nleft_c;
  logic [7:0]            depth_r, depth_nxt, depth_c;
  logic                  node_open_r, node_open_nxt, nopen_c;

  logic                  out_valid_r;
  bxtp_pkg::token_kind_t out_kind_r;
  logic [15:0]           out_value_r;
  logic [7:0]            out_level_r;
  logic                  out_done_r;

  logic                  advance;
  logic                  emit;
  bxtp_pkg::token_kind_t kind;
  logic [15:0]           value;
  logic                  done;

  logic                  sz_ok;
  logic [15:0]           sz_val;
  logic [1:0]            sz_step_upd;
  logic [7:0]            sz_high_upd;
  logic [15:0]           nleft_dec;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // restart view of the state
  always_comb begin
    if (in_sof_r) begin
      ph_c    = bxtp_pkg::PH_HEADER;
      hdr_c   = '0;
      szs_c   = '0;
      szh_c   = '0;
      ntot_c  = '0;
      nleft_c = '0;
      depth_c = '0;
      nopen_c = 1'b0;
    end else begin
      ph_c    = phase_r;
      hdr_c   = hdr_cnt_r;
      szs_c   = sz_step_r;
      szh_c   = sz_high_r;
      ntot_c  = name_total_r;
      nleft_c = names_left_r;
      depth_c = depth_r;
      nopen_c = node_open_r;
    end
  end

  // escaped size decode: 255 * high + low
  always_comb begin
    sz_ok       = 1'b0;
    sz_val      = {8'd0, in_byte_r};
    sz_step_upd = szs_c;
    sz_high_upd = szh_c;
    unique case (szs_c)
      2'd0: begin
        if (in_byte_r != bxtp_pkg::SIZE_ESC) begin
          sz_ok = 1'b1;
        end else begin
          sz_step_upd = 2'd1;
        end
      end
      2'd1: begin
        sz_high_upd = in_byte_r;
        sz_step_upd = 2'd2;
      end
      default: begin
        sz_step_upd = 2'd0;
        sz_ok       = 1'b1;
        sz_val      = ({szh_c, 8'd0} - {8'd0, szh_c}) + {8'd0, in_byte_r};
      end
    endcase
  end

  assign nleft_dec = nleft_c - 16'd1;

  always_comb begin
    phase_nxt      = ph_c;
    hdr_cnt_nxt    = hdr_c;
    sz_step_nxt    = szs_c;
    sz_high_nxt    = szh_c;
    name_total_nxt = ntot_c;
    names_left_nxt = nleft_c;
    depth_nxt      = depth_c;
    node_open_nxt  = nopen_c;
    emit           = 1'b0;
    kind           = bxtp_pkg::TK_ERROR;
    value          = '0;
    done           = 1'b0;
    unique case (ph_c)
      bxtp_pkg::PH_HEADER: begin
        if (hdr_c == 2'd3) begin
          hdr_cnt_nxt = '0;
          phase_nxt   = bxtp_pkg::PH_TABSIZE;
        end else begin
          hdr_cnt_nxt = hdr_c + 2'd1;
        end
      end
      bxtp_pkg::PH_TABSIZE: begin
        sz_step_nxt = sz_step_upd;
        sz_high_nxt = sz_high_upd;
        if (sz_ok) begin
          name_total_nxt = sz_val;
          names_left_nxt = sz_val;
          phase_nxt = (sz_val == '0) ? bxtp_pkg::PH_NODETYPE : bxtp_pkg::PH_NAMES;
        end
      end
      bxtp_pkg::PH_NAMES: begin
        emit = 1'b1;
        if (in_byte_r != 8'd0) begin
          kind  = bxtp_pkg::TK_NAME_BYTE;
          value = {8'd0, in_byte_r};
        end else begin
          kind           = bxtp_pkg::TK_NAME_END;
          value          = ntot_c - nleft_c;
          names_left_nxt = nleft_dec;
          if (nleft_dec == '0) begin
            phase_nxt = bxtp_pkg::PH_NODETYPE;
          end
        end
      end
      bxtp_pkg::PH_NODETYPE: begin
        priority if (in_byte_r == bxtp_pkg::NT_TEXT) begin
          phase_nxt = bxtp_pkg::PH_TEXT;
        end else if (in_byte_r != bxtp_pkg::NT_CLOSE) begin
          node_open_nxt = (in_byte_r == bxtp_pkg::NT_OPEN);
          sz_step_nxt   = '0;
          phase_nxt     = bxtp_pkg::PH_TAGIDX;
        end else if (depth_c == '0) begin
          emit      = 1'b1;
          phase_nxt = bxtp_pkg::PH_ERROR;
        end else begin
          emit      = 1'b1;
          kind      = bxtp_pkg::TK_CLOSE;
          depth_nxt = depth_c - 8'd1;
          if (depth_c == 8'd1) begin
            done      = 1'b1;
            phase_nxt = bxtp_pkg::PH_DONE;
          end
        end
      end
      bxtp_pkg::PH_TAGIDX: begin
        sz_step_nxt = sz_step_upd;
        sz_high_nxt = sz_high_upd;
        if (sz_ok) begin
          emit = 1'b1;
          if (sz_val >= ntot_c || depth_c >= DepthLimit) begin
            phase_nxt = bxtp_pkg::PH_ERROR;
          end else begin
            kind        = nopen_c ? bxtp_pkg::TK_OPEN : bxtp_pkg::TK_SELF;
            value       = sz_val;
            depth_nxt   = depth_c + 8'd1;
            sz_step_nxt = '0;
            phase_nxt   = bxtp_pkg::PH_ATTRIDX;
          end
        end
      end
      bxtp_pkg::PH_ATTRIDX: begin
        sz_step_nxt = sz_step_upd;
        sz_high_nxt = sz_high_upd;
        if (sz_ok) begin
          if (sz_val == '0) begin
            phase_nxt = bxtp_pkg::PH_NODETYPE;
          end else if ((sz_val - 16'd1) >= ntot_c) begin
            emit      = 1'b1;
            phase_nxt = bxtp_pkg::PH_ERROR;
          end else begin
            emit      = 1'b1;
            kind      = bxtp_pkg::TK_ATTR_NAME;
            value     = sz_val - 16'd1;
            phase_nxt = bxtp_pkg::PH_ATTRVAL;
          end
        end
      end
      bxtp_pkg::PH_ATTRVAL: begin
        emit = 1'b1;
        if (in_byte_r != 8'd0) begin
          kind  = bxtp_pkg::TK_ATTR_BYTE;
          value = {8'd0, in_byte_r};
        end else begin
          kind        = bxtp_pkg::TK_ATTR_END;
          sz_step_nxt = '0;
          phase_nxt   = bxtp_pkg::PH_ATTRIDX;
        end
      end
      bxtp_pkg::PH_TEXT: begin
        emit = 1'b1;
        if (in_byte_r != 8'd0) begin
          kind  = bxtp_pkg::TK_TEXT_BYTE;
          value = {8'd0, in_byte_r};
        end else begin
          kind = bxtp_pkg::TK_TEXT_END;
          if (depth_c == '0) begin
            done      = 1'b1;
            phase_nxt = bxtp_pkg::PH_DONE;
          end else begin
            phase_nxt = bxtp_pkg::PH_NODETYPE;
          end
        end
      end
      bxtp_pkg::PH_DONE: begin
        emit      = 1'b1;
        phase_nxt = bxtp_pkg::PH_ERROR;
      end
      bxtp_pkg::PH_ERROR: begin
      end
      default: begin
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_sof_r  <= in_tuser;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= bxtp_pkg::PH_HEADER;
      hdr_cnt_r    <= '0;
      sz_step_r    <= '0;
      sz_high_r    <= '0;
      name_total_r <= '0;
      names_left_r <= '0;
      depth_r      <= '0;
      node_open_r  <= 1'b0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      sz_step_r    <= sz_step_nxt;
      sz_high_r    <= sz_high_nxt;
      name_total_r <= name_total_nxt;
      names_left_r <= names_left_nxt;
      depth_r      <= depth_nxt;
      node_open_r  <= node_open_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_kind_r  <= kind;
      out_value_r <= value;
      out_level_r <= depth_nxt;
      out_done_r  <= done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_level_r, out_value_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_done_r;

endmodule
